// File: rtl/fmi_pkg.sv
package fmi_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_WIDTH_DEF   = 32;

  localparam int IN_KEY_W = 32;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 9;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_ORIGIN    = 1'b0;
  localparam logic ORIGIN_RESET  = 1'b1;

  typedef struct packed {
    logic valid;
    logic query;
    logic hit;
    logic ovf;
  } fmi_ctl_t;

endpackage

// File: rtl/fmi_cell.sv
module fmi_cell
  import fmi_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int KW    = 32,
  parameter int CW    = 9,
  parameter int PW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  fmi_ctl_t      ctl_in,
  input  logic [KW-1:0] key_in,
  input  logic [CW-1:0] cnt_in,
  input  logic [PW-1:0] pos_in,
  output fmi_ctl_t      ctl_out,
  output logic [KW-1:0] key_out,
  output logic [CW-1:0] cnt_out,
  output logic [PW-1:0] pos_out
);

  localparam logic [CW-1:0] MY_IDX = CW'(INDEX);
  localparam logic [PW-1:0] MY_POS = PW'(INDEX);

  logic [KW-1:0] entry;
  fmi_ctl_t      ctl_next;
  logic [PW-1:0] pos_next;
  logic          wr_en;
  logic          match;

  assign wr_en = ctl_in.valid && !ctl_in.query && (cnt_in == MY_IDX);
  assign match = ctl_in.valid && ctl_in.query && !ctl_in.hit &&
                 (MY_IDX < cnt_in) && (entry == key_in);

  always_comb begin
    ctl_next = ctl_in;
    pos_next = pos_in;
    if (match) begin
      ctl_next.hit = 1'b1;
      pos_next     = MY_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= key_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    key_out <= key_in;
    cnt_out <= cnt_in;
    pos_out <= pos_next;
  end

endmodule

// File: rtl/fmi_cfg.sv
module fmi_cfg
  import fmi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic               origin
);

  logic sel_origin;
  logic wr_en;

  assign pready     = 1'b1;
  assign sel_origin = (paddr[PADDR_W-1] == REG_ORIGIN);
  assign wr_en      = psel && penable && pwrite && pready && sel_origin;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= ORIGIN_RESET;
    end else if (wr_en) begin
      origin <= pwdata[0];
    end
  end

  assign prdata = sel_origin ? PDATA_W'(origin) : '0;

endmodule

// File: rtl/first_match_index_of_core.sv
// First-match index search (index-of). Each accepted word (start high while
// busy is low) enters a chain of TABLE_DEPTH cells, one table entry per cell,
// and moves one cell per clock. Clear takes effect at once; append writes the
// word into the cell at the current count; query compares against every
// valid entry on its way down and the lowest matching index wins. busy stays
// low, so one word can be accepted every clock, and a query's result shows up
// with done once it has passed each cell of the chain and the output registers.
// Results cannot be stalled: sample position, found and overflowed whenever
// done is high. Change index_origin only while no query is in flight.
module first_match_index_of_core
  import fmi_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode,
  input  logic [IN_KEY_W-1:0] key,
  output logic                done,
  output logic [POS_W-1:0]    position,
  output logic                found,
  output logic                overflowed,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int KW = (KEY_WIDTH < IN_KEY_W) ? KEY_WIDTH : IN_KEY_W;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(TABLE_DEPTH);
  localparam int SW = (CW + 1 > POS_W) ? CW + 1 : POS_W;
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  logic          origin;
  logic          accept;
  logic          is_full;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          ovf;
  logic          ovf_next;

  fmi_ctl_t      ctl_w [TABLE_DEPTH+1];
  logic [KW-1:0] key_w [TABLE_DEPTH+1];
  logic [CW-1:0] cnt_w [TABLE_DEPTH+1];
  logic [PW-1:0] pos_w [TABLE_DEPTH+1];

  logic [SW-1:0] sum;

  fmi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .origin  (origin)
  );

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_full = (count == FULL);

  always_comb begin
    count_next = count;
    ovf_next   = ovf;
    if (accept) begin
      if (mode == MODE_CLEAR) begin
        count_next = '0;
        ovf_next   = 1'b0;
      end else if (mode == MODE_APPEND) begin
        if (is_full) begin
          ovf_next = 1'b1;
        end else begin
          count_next = count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  // head of the wave
  always_comb begin
    ctl_w[0].valid = accept && ((mode == MODE_QUERY) ||
                                (mode == MODE_APPEND && !is_full));
    ctl_w[0].query = (mode == MODE_QUERY);
    ctl_w[0].hit   = 1'b0;
    ctl_w[0].ovf   = ovf;
  end

  assign key_w[0] = key[KW-1:0];
  assign cnt_w[0] = count;
  assign pos_w[0] = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    fmi_cell #(
      .INDEX (i),
      .KW    (KW),
      .CW    (CW),
      .PW    (PW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_w[i]),
      .key_in  (key_w[i]),
      .cnt_in  (cnt_w[i]),
      .pos_in  (pos_w[i]),
      .ctl_out (ctl_w[i+1]),
      .key_out (key_w[i+1]),
      .cnt_out (cnt_w[i+1]),
      .pos_out (pos_w[i+1])
    );
  end

  assign sum = (ctl_w[TABLE_DEPTH].hit ? SW'(pos_w[TABLE_DEPTH])
                                       : SW'(cnt_w[TABLE_DEPTH])) + SW'(origin);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_w[TABLE_DEPTH].valid && ctl_w[TABLE_DEPTH].query;
    end
  end

  always_ff @(posedge clk) begin
    position   <= sum[POS_W-1:0];
    found      <= ctl_w[TABLE_DEPTH].hit;
    overflowed <= ctl_w[TABLE_DEPTH].ovf;
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= FULL)
    else $error("entry count beyond table depth");

  a_ovf_when_full: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(count) == FULL)
    else $error("overflow set while table not full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == '0 || count == $past(count) + CW'(1)))
    else $error("entry count moved by more than one append");

  a_ovf_clear: assert property (@(posedge clk) disable iff (rst)
    (ovf && !(accept && mode == MODE_CLEAR)) |=> ovf)
    else $error("overflow flag dropped without clear");
`endif

endmodule

// File: dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fmi_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int DRAIN       = DEPTH + 8;
  localparam int WD_LIMIT    = 8 * (DEPTH + 16);
  localparam int PHASE_WORDS = 130;
  localparam int N_DIR       = 23;

  localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] ORIGIN_ADDR = PADDR_W'(4 * int'(REG_ORIGIN));

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             overflowed;
  } idx_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [IN_KEY_W-1:0] key;
    logic [9:0]          reps;
    logic                typed;
    idx_result_t         res;
  } dir_row_t;

  localparam idx_result_t NO_RES = '0;

  // typed rows assume the reset origin of one
  localparam dir_row_t DIR_TAB [N_DIR] = '{
    '{MODE_QUERY,  32'h0000_0000, 10'd1,   1'b1, '{9'd1,   1'b0, 1'b0}},
    '{MODE_UNUSED, 32'hFFFF_FFFF, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'hFFFF_FFFF, 10'd1,   1'b1, '{9'd1,   1'b0, 1'b0}},
    '{MODE_APPEND, 32'h0000_0000, 10'd1,   1'b0, NO_RES},
    '{MODE_APPEND, 32'hFFFF_FFFF, 10'd1,   1'b0, NO_RES},
    '{MODE_APPEND, 32'h0000_0000, 10'd1,   1'b0, NO_RES},
    '{MODE_APPEND, 32'hA5A5_A5A5, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'h0000_0000, 10'd1,   1'b1, '{9'd1,   1'b1, 1'b0}},
    '{MODE_QUERY,  32'hFFFF_FFFF, 10'd1,   1'b1, '{9'd2,   1'b1, 1'b0}},
    '{MODE_QUERY,  32'hA5A5_A5A5, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'h5A5A_5A5A, 10'd1,   1'b0, NO_RES},
    '{MODE_UNUSED, 32'h0000_0000, 10'd1,   1'b0, NO_RES},
    '{MODE_CLEAR,  32'h0000_0000, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'h0000_0000, 10'd1,   1'b1, '{9'd1,   1'b0, 1'b0}},
    '{MODE_APPEND, 32'h8000_0000, 10'd256, 1'b0, NO_RES},
    '{MODE_APPEND, 32'h1234_5678, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'h8000_00FF, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'h8000_0000, 10'd1,   1'b1, '{9'd1,   1'b1, 1'b1}},
    '{MODE_QUERY,  32'h1234_5678, 10'd1,   1'b1, '{9'd257, 1'b0, 1'b1}},
    '{MODE_CLEAR,  32'hFFFF_FFFF, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'h1234_5678, 10'd1,   1'b1, '{9'd1,   1'b0, 1'b0}},
    '{MODE_APPEND, 32'h1234_5678, 10'd1,   1'b0, NO_RES},
    '{MODE_QUERY,  32'h1234_5678, 10'd1,   1'b0, NO_RES}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   mode;
  logic [IN_KEY_W-1:0] key;
  logic                done;
  logic [POS_W-1:0]    position;
  logic                found;
  logic                overflowed;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  first_match_index_of_core DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .key        (key),
    .done       (done),
    .position   (position),
    .found      (found),
    .overflowed (overflowed),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted table contents
  logic [IN_KEY_W-1:0] key_tab [DEPTH];
  int                  tab_count;
  logic                tab_ovf;
  logic                origin;

  idx_result_t         pending_results [$];
  int                  n_errors;
  int                  words_sent;
  int                  burst_left;
  int                  idle_cycles;
  logic [27:0]         pool_base;
  int n_clear, n_append, n_dropped, n_query, n_hit, n_ovf_query, n_unused;
  int n_origin [2];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic index_of_lookup(input logic [MODE_W-1:0] m, input logic [IN_KEY_W-1:0] k,
                                 output bit has_res, output idx_result_t res);
    int hit_at;
    hit_at  = -1;
    has_res = 1'b0;
    res     = '0;
    case (m)
      MODE_CLEAR: begin
        tab_count = 0;
        tab_ovf   = 1'b0;
        n_clear++;
      end
      MODE_APPEND: begin
        if (tab_count < DEPTH) begin
          key_tab[tab_count] = k;
          tab_count++;
        end else begin
          tab_ovf = 1'b1;
          n_dropped++;
        end
        n_append++;
      end
      MODE_QUERY: begin
        for (int i = 0; i < tab_count; i++) begin
          if (key_tab[i] == k) begin
            hit_at = i;
            break;
          end
        end
        has_res          = 1'b1;
        res.found        = (hit_at >= 0);
        res.position     = POS_W'(((hit_at >= 0) ? hit_at : tab_count) + int'(origin));
        res.overflowed   = tab_ovf;
        n_query++;
        if (res.found) n_hit++;
        if (tab_ovf) n_ovf_query++;
      end
      default: n_unused++;
    endcase
  endtask

  task automatic send_word(input logic [MODE_W-1:0] m, input logic [IN_KEY_W-1:0] k,
                           input logic typed, input idx_result_t typed_res);
    bit          ok;
    bit          has_res;
    idx_result_t res;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    mode  <= m;
    key   <= k;
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    index_of_lookup(m, k, has_res, res);
    if (has_res) pending_results.push_back(typed ? typed_res : res);
    if (m != MODE_UNUSED) words_sent++;
  endtask

  task automatic drain_idle();
    start      <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
                            input logic [PDATA_W-1:0] d, output logic [PDATA_W-1:0] rd);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      rd  = prdata;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_origin_reg();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, ORIGIN_ADDR, '0, rd);
    if (rd !== PDATA_W'(origin))
      report_mismatch($sformatf("index_origin read %0h, want %0h", rd, origin));
  endtask

  task automatic set_origin(input logic v);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, ORIGIN_ADDR, PDATA_W'(v), rd);
    origin = v;
    n_origin[v]++;
    check_origin_reg();
  endtask

  function automatic logic [IN_KEY_W-1:0] pick_key();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return {pool_base, 4'($urandom_range(0, 15))};
  endfunction

  task automatic run_sequence();
    int                  n_app;
    int                  n_qry;
    logic [IN_KEY_W-1:0] added [$];
    logic [IN_KEY_W-1:0] k;
    pool_base = 28'($urandom);
    if ($urandom_range(0, 9) != 0) send_word(MODE_CLEAR, $urandom, 1'b0, NO_RES);
    n_app = ($urandom_range(0, 11) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 24);
    for (int i = 0; i < n_app; i++) begin
      k = pick_key();
      send_word(MODE_APPEND, k, 1'b0, NO_RES);
      added.push_back(k);
      if ($urandom_range(0, 7) == 0) send_word(MODE_QUERY, pick_key(), 1'b0, NO_RES);
      if ($urandom_range(0, 19) == 0) send_word(MODE_UNUSED, $urandom, 1'b0, NO_RES);
    end
    n_qry = $urandom_range(4, 24);
    for (int i = 0; i < n_qry; i++) begin
      case ($urandom_range(0, 19))
        0: send_word(MODE_UNUSED, $urandom, 1'b0, NO_RES);
        1: send_word(MODE_CLEAR, $urandom, 1'b0, NO_RES);
        2: send_word(MODE_APPEND, pick_key(), 1'b0, NO_RES);
        3, 4, 5, 6, 7, 8, 9, 10, 11: begin
          if (added.size() > 0) k = added[$urandom_range(0, added.size() - 1)];
          else k = pick_key();
          send_word(MODE_QUERY, k, 1'b0, NO_RES);
        end
        default: send_word(MODE_QUERY, pick_key(), 1'b0, NO_RES);
      endcase
    end
  endtask

  always @(negedge clk) begin
    idx_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result pos=%0d found=%0b ovf=%0b",
                                  position, found, overflowed));
      end else begin
        want = pending_results.pop_front();
        if (position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d", position, want.position));
        if (found !== want.found)
          report_mismatch($sformatf("found %0b, want %0b", found, want.found));
        if (overflowed !== want.overflowed)
          report_mismatch($sformatf("overflowed %0b, want %0b", overflowed, want.overflowed));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [PADDR_W-1:0] unused_addr;
    logic               next_origin;
    unused_addr = '0;
    rst     = 1'b1;
    start   = 1'b0;
    mode    = MODE_CLEAR;
    key     = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = unused_addr;
    pwdata  = '0;
    tab_count   = 0;
    tab_ovf     = 1'b0;
    origin      = ORIGIN_RESET;
    n_errors    = 0;
    words_sent  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_origin_reg();

    foreach (DIR_TAB[r]) begin
      for (int i = 0; i < int'(DIR_TAB[r].reps); i++)
        send_word(DIR_TAB[r].mode, DIR_TAB[r].key + IN_KEY_W'(i),
                  DIR_TAB[r].typed, DIR_TAB[r].res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain_idle();
      case (ph)
        0: next_origin = 1'b0;
        1: next_origin = 1'b1;
        2: next_origin = 1'b0;
        default: next_origin = 1'($urandom_range(0, 1));
      endcase
      set_origin(next_origin);
      while (words_sent < N_DIR + 255 + (ph + 1) * PHASE_WORDS) run_sequence();
    end
    drain_idle();

    $display("words: %0d clear, %0d append (%0d dropped), %0d query",
             n_clear, n_append, n_dropped, n_query);
    $display("queries: %0d hit, %0d after drop; %0d unused words",
             n_hit, n_ovf_query, n_unused);
    $display("index_origin written: 0 x%0d, 1 x%0d; mismatches: %0d",
             n_origin[0], n_origin[1], n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
